### hw/rtl/smf_pkg.sv
package smf_pkg;

    // Default sizes of the filter
    localparam int WINDOW_MAX_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 24;

    // Window size register
    localparam int                CFG_W           = 5;
    localparam logic [CFG_W-1:0]  WINDOW_SIZE_RST = 5'd5;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_EVICT,
        OP_SHIFT,
        OP_INSERT,
        OP_CLEAR
    } t_cell_op;

endpackage

### hw/rtl/smf_if.sv
// Input channel: one sample word per handshake
interface smf_in_if #(
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// Output channel: one median word per handshake
interface smf_out_if #(
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

### hw/rtl/sliding_median_filter.sv
// Channel    | Dir | Word                            | Handshake
// -----------+-----+---------------------------------+------------------
// i_in       | in  | sample, last_sample             | valid / ready
// o_out      | out | median                          | valid / ready
// i_cfg_*    | in  | window_size (wdata)             | write enable only
//
// Each sample passes through accept (drop old samples and age the rest), one
// gap close step per gap in the cell chain, insert, and median pick, in order.
// Shrinking the window adds up to one gap close step per extra sample dropped.
// Reset is synchronous: the chain empties and window_size returns to 5. A
// median waits in the output register while the next sample is accepted;
// only the median step stalls on a full output.
module sliding_median_filter #(
    parameter int WINDOW_MAX  = smf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
    localparam int AW         = $clog2(WINDOW_MAX),
    localparam int WSW        = $clog2(WINDOW_MAX + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [smf_pkg::CFG_W-1:0]   i_cfg_wdata,
    smf_in_if.sink                      i_in,
    smf_out_if.source                   o_out
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_COMPACT = 3'b010,
        ST_MEDIAN  = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [smf_pkg::CFG_W-1:0]     r_window_size;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_last;
    logic [WSW-1:0]                w_ws;
    smf_pkg::t_cell_op             w_op;
    logic                          w_gap;
    logic                          w_can_load;
    logic                          w_load;

    logic                          w_valid [WINDOW_MAX];
    logic [AW-1:0]                 w_age   [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_value [WINDOW_MAX];
    logic                          w_le    [WINDOW_MAX];
    logic                          w_hole  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         w_valid_vec;
    logic [2*SAMPLE_BITS-1:0]      w_pair  [WINDOW_MAX];

    // Window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= smf_pkg::WINDOW_SIZE_RST;
        end else if (i_cfg_we) begin
            r_window_size <= i_cfg_wdata;
        end
    end

    // Effective size: zero means one, large values saturate
    always_comb begin
        if (r_window_size == '0) begin
            w_ws = WSW'(1);
        end else if (32'(r_window_size) > 32'(WINDOW_MAX)) begin
            w_ws = WSW'(WINDOW_MAX);
        end else begin
            w_ws = WSW'(r_window_size);
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);

    // Latch the incoming word
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_x    <= i_in.sample;
            r_last <= i_in.last_sample;
        end
    end

    // A gap is an empty slot with a kept sample above it
    always_comb begin
        w_gap = 1'b0;
        for (int i = 0; i < WINDOW_MAX - 1; i++) begin
            w_gap = w_gap | (!w_valid[i] && w_valid[i+1]);
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        w_op    = smf_pkg::OP_HOLD;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    w_op    = smf_pkg::OP_EVICT;
                    n_state = ST_COMPACT;
                end
            end
            ST_COMPACT: begin
                if (w_gap) begin
                    w_op = smf_pkg::OP_SHIFT;
                end else begin
                    w_op    = smf_pkg::OP_INSERT;
                    n_state = ST_MEDIAN;
                end
            end
            ST_MEDIAN: begin
                if (w_can_load) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_last) begin
                        w_op = smf_pkg::OP_CLEAR;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Chain of cells, sorted ascending from index 0
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic                          lo_valid, lo_le, lo_hole, hi_valid;
        logic [AW-1:0]                 lo_age, hi_age;
        logic signed [SAMPLE_BITS-1:0] lo_value, hi_value;

        if (g == 0) begin : g_bottom
            assign lo_valid = 1'b0;
            assign lo_age   = '0;
            assign lo_value = '0;
            assign lo_le    = 1'b1;
            assign lo_hole  = 1'b0;
        end else begin : g_lower
            assign lo_valid = w_valid[g-1];
            assign lo_age   = w_age[g-1];
            assign lo_value = w_value[g-1];
            assign lo_le    = w_le[g-1];
            assign lo_hole  = w_hole[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_top
            assign hi_valid = 1'b0;
            assign hi_age   = '0;
            assign hi_value = '0;
        end else begin : g_upper
            assign hi_valid = w_valid[g+1];
            assign hi_age   = w_age[g+1];
            assign hi_value = w_value[g+1];
        end

        smf_cell #(
            .WINDOW_MAX  (WINDOW_MAX),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (w_op),
            .i_ws       (w_ws),
            .i_x        (r_x),
            .i_lo_valid (lo_valid),
            .i_lo_age   (lo_age),
            .i_lo_value (lo_value),
            .i_lo_le    (lo_le),
            .i_lo_hole  (lo_hole),
            .i_hi_valid (hi_valid),
            .i_hi_age   (hi_age),
            .i_hi_value (hi_value),
            .o_valid    (w_valid[g]),
            .o_age      (w_age[g]),
            .o_value    (w_value[g]),
            .o_le       (w_le[g]),
            .o_hole     (w_hole[g])
        );

        assign w_valid_vec[g] = w_valid[g];
        assign w_pair[g]      = {lo_value, w_value[g]};
    end

    smf_median #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_ws       (w_ws),
        .i_valid    (w_valid_vec),
        .i_pair     (w_pair),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

endmodule

### hw/rtl/smf_cell.sv
// One slot of the sorted window: value, age and a valid bit.
module smf_cell #(
    parameter int WINDOW_MAX  = smf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
    localparam int AW         = $clog2(WINDOW_MAX),
    localparam int WSW        = $clog2(WINDOW_MAX + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smf_pkg::t_cell_op             i_op,
    input  logic [WSW-1:0]                i_ws,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    // neighbor below (lower index, smaller values)
    input  logic                          i_lo_valid,
    input  logic [AW-1:0]                 i_lo_age,
    input  logic signed [SAMPLE_BITS-1:0] i_lo_value,
    input  logic                          i_lo_le,
    input  logic                          i_lo_hole,
    // neighbor above
    input  logic                          i_hi_valid,
    input  logic [AW-1:0]                 i_hi_age,
    input  logic signed [SAMPLE_BITS-1:0] i_hi_value,
    // own state
    output logic                          o_valid,
    output logic [AW-1:0]                 o_age,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                          o_le,
    output logic                          o_hole
);

    logic                          r_valid, n_valid;
    logic [AW-1:0]                 r_age, n_age;
    logic signed [SAMPLE_BITS-1:0] r_value, n_value;
    logic                          w_keep;

    // le: kept value does not exceed the new sample (stable insert)
    assign o_le    = r_valid && (r_value <= i_x);
    // hole: an empty slot at or below this one
    assign o_hole  = !r_valid || i_lo_hole;
    assign w_keep  = (WSW'(r_age) + WSW'(1)) < i_ws;

    assign o_valid = r_valid;
    assign o_age   = r_age;
    assign o_value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        n_value = r_value;
        case (i_op)
            smf_pkg::OP_EVICT: begin
                if (r_valid) begin
                    if (w_keep) begin
                        n_age = r_age + AW'(1);
                    end else begin
                        n_valid = 1'b0;
                    end
                end
            end
            smf_pkg::OP_SHIFT: begin
                // close the lowest hole by pulling everything above down one
                if (o_hole) begin
                    n_valid = i_hi_valid;
                    n_age   = i_hi_age;
                    n_value = i_hi_value;
                end
            end
            smf_pkg::OP_INSERT: begin
                if (!o_le) begin
                    if (i_lo_le) begin
                        n_valid = 1'b1;
                        n_age   = '0;
                        n_value = i_x;
                    end else begin
                        n_valid = i_lo_valid;
                        n_age   = i_lo_age;
                        n_value = i_lo_value;
                    end
                end
            end
            smf_pkg::OP_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_age   <= n_age;
        r_value <= n_value;
    end

endmodule

### hw/rtl/smf_median.sv
// Median pick from the sorted chain and output register.
module smf_median #(
    parameter int WINDOW_MAX  = smf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
    localparam int AW         = $clog2(WINDOW_MAX),
    localparam int WSW        = $clog2(WINDOW_MAX + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [WSW-1:0]               i_ws,
    input  logic [WINDOW_MAX-1:0]        i_valid,
    // each entry: {value of the cell below, value of this cell}
    input  logic [2*SAMPLE_BITS-1:0]     i_pair [WINDOW_MAX],
    output logic                         o_can_load,
    smf_out_if.source                    o_out
);

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_median, n_median;
    logic [AW-1:0]                 w_mid;
    logic [AW-1:0]                 w_top;
    logic [2*SAMPLE_BITS-1:0]      w_pair;
    logic signed [SAMPLE_BITS-1:0] w_lo, w_hi;
    logic signed [SAMPLE_BITS:0]   w_sum;
    logic                          w_full;

    assign w_mid  = AW'(i_ws >> 1);
    assign w_top  = AW'(i_ws - WSW'(1));
    assign w_full = i_valid[w_top];
    assign w_pair = i_pair[w_mid];
    assign w_lo   = signed'(w_pair[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign w_hi   = signed'(w_pair[SAMPLE_BITS-1:0]);
    assign w_sum  = {w_lo[SAMPLE_BITS-1], w_lo} + {w_hi[SAMPLE_BITS-1], w_hi};

    // odd window: middle cell; even: floor of the mean of the two middle cells
    always_comb begin
        if (i_ws[0]) begin
            n_median = w_hi;
        end else begin
            n_median = w_sum[SAMPLE_BITS:1];
        end
    end

    assign o_can_load   = !r_valid || o_out.ready;
    assign o_out.valid  = r_valid;
    assign o_out.median = r_median;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && o_can_load && w_full) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load && w_full) begin
            r_median <= n_median;
        end
    end

endmodule
